/* design/utd_pkg.sv */
`default_nettype none

package utd_pkg;

    // Default width of the byte and unit counters.
    localparam int COUNT_WIDTH_DEF = 16;

    // One result word as it leaves the block.
    typedef struct packed {
        logic        is_summary;
        logic [15:0] code_unit;
        logic [15:0] bytes_consumed;
        logic [15:0] units_produced;
    } result_t;

    // Up to two result words produced by one input byte, unit word first.
    typedef struct packed {
        logic    unit_valid;
        logic    summary_valid;
        result_t unit;
        result_t summary;
    } push_t;

endpackage

`default_nettype wire

/* design/utf8_to_utf16_decoder.sv */
// UTF-8 to 16-bit code unit decoder.
// Bytes of a string enter on the s_ channel, one word per byte, with s_tlast
// on the final byte of the buffer. Decoded code units leave on the m_ channel;
// the final byte also produces a summary word, marked by m_tlast, carrying the
// bytes consumed and units produced for the run, after which the run restarts.
// The cfg_ channel sets the unit limit (zero counts units without sending
// them) and is always ready; it is to be written only while the block is
// idle, a rule on the user that the block itself does not enforce.
// An accepted byte is held in the input register and is decoded from there
// into the result queue when the queue has room, and its word then shows on
// m_tvalid. One byte is taken every cycle while the queue has room; the final
// byte of a run yields up to two words, which leave unit word first.
// When the receiver stalls, the four-word result queue absorbs the backlog,
// then s_tready drops until there is room for two words again.
// Reset clears the held sequence, the counters, the limit and the queue.
`default_nettype none

module utf8_to_utf16_decoder #(
    parameter int COUNT_WIDTH = utd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,    // in_byte
    input  wire logic          s_tlast,    // is_last
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [47:0]        m_tdata,    // code_unit, bytes_consumed, units_produced
    output logic               m_tlast,    // is_summary
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [15:0]   cfg_data    // output_limit
);

    utd_pkg::push_t push;
    logic           space;

    assign cfg_ready = 1'b1;

    utd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .space     (space),
        .push      (push)
    );

    utd_result_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

/* design/utd_core.sv */
`default_nettype none

module utd_core #(
    parameter int COUNT_WIDTH = utd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          s_tlast,
    input  wire logic          cfg_valid,
    input  wire logic [15:0]   cfg_data,
    input  wire logic          space,
    output utd_pkg::push_t     push
);

    typedef enum logic [1:0] {
        HELD_NONE   = 2'd0,
        HELD_LEAD   = 2'd1,
        HELD_FOLLOW = 2'd2
    } held_t;

    localparam int CW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [7:0] MASK_TOP  = 8'h80;
    localparam logic [7:0] MASK_LEAD2 = 8'he0;
    localparam logic [7:0] CODE_LEAD2 = 8'hc0;
    localparam logic [7:0] MASK_LEAD3 = 8'hf0;
    localparam logic [7:0] CODE_LEAD3 = 8'he0;
    localparam logic [7:0] BITS_LEAD2 = 8'h1f;
    localparam logic [7:0] BITS_FOLLOW = 8'h3f;
    localparam logic [7:0] BITS_LEAD3 = 8'h0f;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic [15:0]            limit_reg;
    logic [7:0]             lead_reg, lead_next;
    logic [7:0]             follow_reg, follow_next;
    held_t                  held_reg, held_next;
    logic [COUNT_WIDTH-1:0] byte_cnt_reg, byte_cnt_next;
    logic [COUNT_WIDTH-1:0] unit_cnt_reg, unit_cnt_next;
    logic                   stopped_reg, stopped_next;

    logic                   advance;
    logic                   limit_hit;
    logic [1:0]             byte_inc;
    logic                   unit_emit;
    logic [15:0]            unit_val;
    logic                   stopped_main;
    logic [COUNT_WIDTH:0]   byte_sum;
    logic [COUNT_WIDTH:0]   unit_sum;
    logic [COUNT_WIDTH-1:0] byte_sat;
    logic [COUNT_WIDTH-1:0] unit_sat;

    function automatic logic [15:0] report16(input logic [COUNT_WIDTH-1:0] c);
        logic [CW-1:0] ext;
        ext = CW'(c);
        return (ext > CW'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
    endfunction

    assign advance  = in_valid_reg && space;
    assign s_tready = !in_valid_reg || space;

    assign limit_hit = (limit_reg != 16'd0) && (CW'(unit_cnt_reg) >= CW'(limit_reg));

    always_comb
    begin
        lead_next    = lead_reg;
        follow_next  = follow_reg;
        held_next    = held_reg;
        stopped_main = stopped_reg;
        byte_inc     = 2'd0;
        unit_emit    = 1'b0;
        unit_val     = 16'd0;

        if (!stopped_reg)
        begin
            case (held_reg)
                HELD_NONE:
                begin
                    if (in_byte_reg == 8'd0 || limit_hit)
                    begin
                        stopped_main = 1'b1;
                    end
                    else if ((in_byte_reg & MASK_TOP) == 8'd0)
                    begin
                        unit_emit = 1'b1;
                        unit_val  = {8'd0, in_byte_reg};
                        byte_inc  = 2'd1;
                    end
                    else if ((in_byte_reg & MASK_LEAD2) == CODE_LEAD2 ||
                             (in_byte_reg & MASK_LEAD3) == CODE_LEAD3)
                    begin
                        lead_next = in_byte_reg;
                        held_next = HELD_LEAD;
                    end
                    else
                    begin
                        byte_inc = 2'd1;
                    end
                end
                HELD_LEAD:
                begin
                    if ((lead_reg & MASK_LEAD2) == CODE_LEAD2)
                    begin
                        unit_emit = 1'b1;
                        unit_val  = {5'd0, lead_reg[4:0] & BITS_LEAD2[4:0],
                                     in_byte_reg[5:0] & BITS_FOLLOW[5:0]};
                        byte_inc  = 2'd2;
                        held_next = HELD_NONE;
                    end
                    else
                    begin
                        follow_next = in_byte_reg;
                        held_next   = HELD_FOLLOW;
                    end
                end
                default:
                begin
                    unit_emit = 1'b1;
                    unit_val  = {lead_reg[3:0] & BITS_LEAD3[3:0],
                                 follow_reg[5:0] & BITS_FOLLOW[5:0],
                                 in_byte_reg[5:0] & BITS_FOLLOW[5:0]};
                    byte_inc  = 2'd3;
                    held_next = HELD_NONE;
                end
            endcase
        end

        // A sequence cut short by the final byte: the lead is consumed and a
        // held follower is looked at once more as a lead. No unit was made
        // above in this case, so the unit count is still the old one.
        if (in_last_reg && !stopped_main && held_next != HELD_NONE)
        begin
            byte_inc = 2'd1;
            if (held_next == HELD_FOLLOW && follow_next != 8'd0 && !limit_hit)
            begin
                if ((follow_next & MASK_TOP) == 8'd0)
                begin
                    unit_emit = 1'b1;
                    unit_val  = {8'd0, follow_next};
                end
                byte_inc = 2'd2;
            end
        end
    end

    assign byte_sum = {1'b0, byte_cnt_reg} + (COUNT_WIDTH+1)'(byte_inc);
    assign unit_sum = {1'b0, unit_cnt_reg} + (COUNT_WIDTH+1)'(unit_emit);
    assign byte_sat = byte_sum[COUNT_WIDTH] ? CNT_MAX : byte_sum[COUNT_WIDTH-1:0];
    assign unit_sat = unit_sum[COUNT_WIDTH] ? CNT_MAX : unit_sum[COUNT_WIDTH-1:0];

    always_comb
    begin
        if (in_last_reg)
        begin
            stopped_next  = 1'b0;
            byte_cnt_next = '0;
            unit_cnt_next = '0;
        end
        else
        begin
            stopped_next  = stopped_main;
            byte_cnt_next = byte_sat;
            unit_cnt_next = unit_sat;
        end
    end

    always_comb
    begin
        push.unit_valid               = advance && unit_emit && (limit_reg != 16'd0);
        push.unit.is_summary          = 1'b0;
        push.unit.code_unit           = unit_val;
        push.unit.bytes_consumed      = 16'd0;
        push.unit.units_produced      = 16'd0;
        push.summary_valid            = advance && in_last_reg;
        push.summary.is_summary       = 1'b1;
        push.summary.code_unit        = 16'd0;
        push.summary.bytes_consumed   = report16(byte_sat);
        push.summary.units_produced   = report16(unit_sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            limit_reg    <= 16'd0;
            lead_reg     <= 8'd0;
            follow_reg   <= 8'd0;
            held_reg     <= HELD_NONE;
            byte_cnt_reg <= '0;
            unit_cnt_reg <= '0;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (advance)
            begin
                lead_reg     <= in_last_reg ? 8'd0 : lead_next;
                follow_reg   <= in_last_reg ? 8'd0 : follow_next;
                held_reg     <= in_last_reg ? HELD_NONE : held_next;
                byte_cnt_reg <= byte_cnt_next;
                unit_cnt_reg <= unit_cnt_next;
                stopped_reg  <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

endmodule

`default_nettype wire

/* design/utd_result_queue.sv */
`default_nettype none

module utd_result_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire utd_pkg::push_t    push,
    output logic                   space,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [47:0]            m_tdata,
    output logic                   m_tlast
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    utd_pkg::result_t    entry_reg [DEPTH];
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg;
    logic [AW:0]         count_reg, count_next;
    logic [AW-1:0]       second_ptr;
    logic                pop;
    utd_pkg::result_t    head;

    // Room for the two words a final byte can produce.
    assign space    = count_reg <= (AW+1)'(DEPTH - 2);
    assign m_tvalid = count_reg != '0;
    assign pop      = m_tvalid && m_tready;
    assign head     = entry_reg[rd_ptr_reg];
    assign m_tdata  = {head.units_produced, head.bytes_consumed, head.code_unit};
    assign m_tlast  = head.is_summary;

    assign second_ptr  = wr_ptr_reg + AW'(push.unit_valid);
    assign wr_ptr_next = second_ptr + AW'(push.summary_valid);
    assign count_next  = count_reg + (AW+1)'(push.unit_valid) + (AW+1)'(push.summary_valid)
                         - (AW+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.unit_valid)
        begin
            entry_reg[wr_ptr_reg] <= push.unit;
        end
        if (push.summary_valid)
        begin
            entry_reg[second_ptr] <= push.summary;
        end
    end

endmodule

`default_nettype wire

/* dv/utf8_to_utf16_decoder_checker.sv */
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,    // in_byte
    input  wire logic        s_tlast,    // is_last
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,    // code_unit, bytes_consumed, units_produced
    input  wire logic        m_tlast,    // is_summary
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [15:0] cfg_data,   // output_limit
    output int               pending,
    output int               errors
);

    localparam logic [7:0] LEAD2_MASK = 8'he0;
    localparam logic [7:0] LEAD2_CODE = 8'hc0;
    localparam logic [7:0] LEAD3_MASK = 8'hf0;
    localparam logic [7:0] LEAD3_CODE = 8'he0;
    localparam int         REPORT_MAX = 10;

    logic [15:0]      unit_limit;
    logic [7:0]       lead_byte;
    logic [7:0]       follow_byte;
    logic [1:0]       held;
    logic [15:0]      byte_total;
    logic [15:0]      unit_total;
    logic             halted;
    utd_pkg::result_t expected_words[$];
    int               mismatches;

    function automatic logic [15:0] sat_add16(input logic [15:0] c, input logic [2:0] d);
        logic [16:0] s;
        s = {1'b0, c} + {14'd0, d};
        return s[16] ? 16'hffff : s[15:0];
    endfunction

    // A unit is always counted, but only sent when a limit is set.
    function automatic void emit_unit(input logic [15:0] u);
        utd_pkg::result_t r;
        if (unit_limit != 16'd0)
        begin
            r = '0;
            r.code_unit = u;
            expected_words.push_back(r);
        end
        unit_total = sat_add16(unit_total, 3'd1);
    endfunction

    function automatic bit lead_allowed(input logic [7:0] b);
        if (halted)
            return 1'b0;
        if (b == 8'h00 || (unit_limit != 16'd0 && unit_total >= unit_limit))
        begin
            halted = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_string();
        lead_byte   = 8'h00;
        follow_byte = 8'h00;
        held        = 2'd0;
        byte_total  = 16'd0;
        unit_total  = 16'd0;
        halted      = 1'b0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        utd_pkg::result_t r;
        if (!halted)
        begin
            if (held == 2'd0)
            begin
                if (lead_allowed(b))
                begin
                    if (b[7] == 1'b0)
                    begin
                        emit_unit({8'h00, b});
                        byte_total = sat_add16(byte_total, 3'd1);
                    end
                    else if ((b & LEAD2_MASK) == LEAD2_CODE || (b & LEAD3_MASK) == LEAD3_CODE)
                    begin
                        lead_byte = b;
                        held = 2'd1;
                    end
                    else
                        byte_total = sat_add16(byte_total, 3'd1);
                end
            end
            else if (held == 2'd1)
            begin
                if ((lead_byte & LEAD2_MASK) == LEAD2_CODE)
                begin
                    emit_unit({5'b00000, lead_byte[4:0], b[5:0]});
                    byte_total = sat_add16(byte_total, 3'd2);
                    held = 2'd0;
                end
                else
                begin
                    follow_byte = b;
                    held = 2'd2;
                end
            end
            else
            begin
                emit_unit({lead_byte[3:0], follow_byte[5:0], b[5:0]});
                byte_total = sat_add16(byte_total, 3'd3);
                held = 2'd0;
            end
        end

        if (last)
        begin
            // A cut-short sequence loses its lead; a held follower is retried as a lead.
            if (!halted && held != 2'd0)
            begin
                byte_total = sat_add16(byte_total, 3'd1);
                if (held == 2'd2 && lead_allowed(follow_byte))
                begin
                    if (follow_byte[7] == 1'b0)
                        emit_unit({8'h00, follow_byte});
                    byte_total = sat_add16(byte_total, 3'd1);
                end
            end
            r = '0;
            r.is_summary     = 1'b1;
            r.bytes_consumed = byte_total;
            r.units_produced = unit_total;
            expected_words.push_back(r);
            clear_string();
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("time %0t: %s expected %h, got %h", $realtime, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        utd_pkg::result_t want;
        if (!rst_n)
        begin
            unit_limit = 16'd0;
            clear_string();
            expected_words.delete();
            mismatches = 0;
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("time %0t: unexpected word, tlast %b data %h",
                                 $realtime, m_tlast, m_tdata);
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("is_summary", {15'd0, want.is_summary}, {15'd0, m_tlast});
                    check_field("code_unit", want.code_unit, m_tdata[15:0]);
                    check_field("bytes_consumed", want.bytes_consumed, m_tdata[31:16]);
                    check_field("units_produced", want.units_produced, m_tdata[47:32]);
                end
            end
            if (cfg_valid && cfg_ready)
                unit_limit = cfg_data;
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            pending <= expected_words.size();
            errors  <= mismatches;
        end
    end

endmodule

/* dv/utf8_to_utf16_decoder_test.sv */
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_test;

    localparam int PHASE_BYTES = 250;
    localparam int SETTLE      = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'h0000;

    int          pending;
    int          errors;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          bytes_sent = 0;
    logic [7:0]  text_q[$];

    utf8_to_utf16_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    utf8_to_utf16_decoder_checker decode_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_byte(input logic [7:0] b, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    // Lets the block drain, including bytes that leave no word behind.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_limit();
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hffff;
            3, 4:    return 16'($urandom_range(8, 2));
            default: return r;
        endcase
    endfunction

    // Followers are mostly well formed, but their top bits are not checked.
    function automatic void push_follower();
        logic [7:0] r;
        r = 8'($urandom);
        if ($urandom_range(9) == 0)
            text_q.push_back(r);
        else
            text_q.push_back({2'b10, r[5:0]});
    endfunction

    function automatic void make_text();
        int         chars;
        int         kind;
        logic [7:0] r;
        text_q.delete();
        chars = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
        for (int i = 0; i < chars; i++)
        begin
            kind = $urandom_range(99);
            r = 8'($urandom);
            if (kind < 40)
                text_q.push_back(8'($urandom_range(127, 1)));
            else if (kind < 60)
            begin
                text_q.push_back({3'b110, r[4:0]});
                push_follower();
            end
            else if (kind < 80)
            begin
                text_q.push_back({4'b1110, r[3:0]});
                push_follower();
                push_follower();
            end
            else if (kind < 87)
                text_q.push_back(r[6] ? {2'b10, r[5:0]} : {4'b1111, r[3:0]});
            else if (kind < 90)
                text_q.push_back(8'h00);
            else
                text_q.push_back(r);
        end
        // Sometimes the string ends in the middle of a sequence.
        if ($urandom_range(99) < 20)
        begin
            r = 8'($urandom);
            kind = $urandom_range(2);
            text_q.push_back(kind == 0 ? {3'b110, r[4:0]} : {4'b1110, r[3:0]});
            if (kind == 2)
            begin
                r = 8'($urandom);
                case ($urandom_range(9))
                    0:       text_q.push_back(8'h00);
                    1, 2, 3: text_q.push_back(r);
                    default: text_q.push_back({1'b0, r[6:0]});
                endcase
            end
        end
    endfunction

    task automatic run_directed();
        // Count only, straight after reset.
        text_q = '{8'hc3, 8'ha9, 8'h41};
        send_text();
        wait_idle();
        write_limit(16'hffff);
        // Field extremes, a zero follower and skipped leads.
        text_q = '{8'h01, 8'h7f, 8'hc2, 8'h00, 8'hdf, 8'hbf, 8'he0, 8'h80, 8'h80,
                   8'hef, 8'hbf, 8'hbf, 8'h80, 8'hff};
        send_text();
        // Cut short with a held follower that is plain, multi-byte and zero.
        text_q = '{8'he4, 8'h41};
        send_text();
        text_q = '{8'he4, 8'hc3};
        send_text();
        text_q = '{8'he4, 8'h00};
        send_text();
        // Zero lead stops the string; the rest is ignored.
        text_q = '{8'h41, 8'h00, 8'h42};
        send_text();
        wait_idle();
        write_limit(16'd1);
        text_q = '{8'h41, 8'h42};
        send_text();
        wait_idle();
    endtask

    initial
    begin
        int phase_end;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 7;
                    recv_idle_pct = 59;
                end
                1:
                begin
                    send_idle_pct = 59;
                    recv_idle_pct = 7;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0)
                run_directed();
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
            begin
                if ($urandom_range(3) == 0)
                begin
                    wait_idle();
                    write_limit(pick_limit());
                end
                make_text();
                send_text();
            end
        end

        wait_idle();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
design/utd_pkg.sv
design/utd_core.sv
design/utd_result_queue.sv
design/utf8_to_utf16_decoder.sv
dv/utf8_to_utf16_decoder_checker.sv
dv/utf8_to_utf16_decoder_test.sv
